### design/mssp_pkg.sv
// ----------------------------------------------------------------------------
// mssp_pkg
// Shared constants, codes and the request payload type for the multi-stack shared pool.
// ----------------------------------------------------------------------------
package mssp_pkg;

   localparam int NUM_SLOTS_DEF  = 64;
   localparam int NUM_STACKS_DEF = 4;

   localparam int CMD_W    = 1;
   localparam int SID_W    = 2;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;

   localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
   localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic        [CMD_W-1:0]  command;
      logic        [SID_W-1:0]  stack_id;
      logic signed [DATA_W-1:0] push_data;
   } req_type;

endpackage

### design/mssp_ifs.sv
// ----------------------------------------------------------------------------
// mssp channel interfaces
// Valid/ready request and response channels of the multi-stack shared pool.
// ----------------------------------------------------------------------------
interface mssp_req_if;
   logic                               valid;
   logic                               ready;
   logic        [mssp_pkg::CMD_W-1:0]  command;
   logic        [mssp_pkg::SID_W-1:0]  stack_id;
   logic signed [mssp_pkg::DATA_W-1:0] push_data;

   modport source (output valid, command, stack_id, push_data, input ready);
   modport sink   (input valid, command, stack_id, push_data, output ready);
endinterface

interface mssp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [mssp_pkg::DATA_W-1:0]   pop_data;
   logic        [mssp_pkg::STATUS_W-1:0] status;
   logic                                 pool_full;
   logic                                 stack_empty;

   modport source (output valid, pop_data, status, pool_full, stack_empty, input ready);
   modport sink   (input valid, pop_data, status, pool_full, stack_empty, output ready);
endinterface

### design/multi_stack_shared_pool_top.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_pool_top
// Several linked stacks sharing one slot pool with a linked free list.
// ----------------------------------------------------------------------------
// path: a request is held in the input stage registers, then its response in the result stage
// throughput: one push or pop per cycle while the response channel is not stalled, set by
//   updating the head/next registers directly, with the one link memory read port forwarded
// reset: synchronous; a fill counter stands in for the initial free list,
//   so there is no clearing pass and requests are taken right after reset
module multi_stack_shared_pool_top #(
   parameter int NUM_SLOTS  = mssp_pkg::NUM_SLOTS_DEF,
   parameter int NUM_STACKS = mssp_pkg::NUM_STACKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   mssp_req_if.sink         req_chan,
   mssp_rsp_if.source       rsp_chan
);

   localparam int AW = $clog2(NUM_SLOTS);
   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
   localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

   // memories
   logic signed [mssp_pkg::DATA_W-1:0] word_mem [NUM_SLOTS];
   logic        [LW-1:0]               link_mem [NUM_SLOTS];

   // input stage
   logic              in_valid_ff;
   mssp_pkg::req_type in_ff;

   // list state
   logic [LW-1:0] free_head_ff, free_head_in;
   logic [LW-1:0] free_next_ff, free_next_in;
   logic [LW-1:0] fill_ff, fill_in;
   logic [LW-1:0] stack_head_ff [NUM_STACKS];
   logic [LW-1:0] stack_head_in [NUM_STACKS];
   logic [LW-1:0] stack_next_ff [NUM_STACKS];
   logic [LW-1:0] stack_next_in [NUM_STACKS];

   // pending link read
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_is_pop_ff, pend_is_pop_in;
   logic [SW-1:0] pend_sid_ff, pend_sid_in;
   logic [LW-1:0] link_rd_ff;

   // result stage
   logic                                 rsp_valid_ff;
   logic [mssp_pkg::STATUS_W-1:0]        status_ff, status_in;
   logic                                 pool_full_ff, pool_full_in;
   logic                                 stack_empty_ff, stack_empty_in;
   logic                                 pop_hit_ff, pop_hit_in;
   logic signed [mssp_pkg::DATA_W-1:0]   word_rd_ff;

   // combinational
   logic          process;
   logic          is_pop;
   logic          sid_ok;
   logic [SW-1:0] sid_idx;
   logic [LW-1:0] cur_head;
   logic [LW-1:0] free_next_eff;
   logic [LW-1:0] stack_next_eff [NUM_STACKS];
   logic [LW-1:0] x_link;
   logic          x_read;
   logic [LW-1:0] x_direct;
   logic          link_wr_en, link_rd_en, word_wr_en, word_rd_en;
   logic [AW-1:0] link_wr_addr, link_rd_addr, word_addr;
   logic [LW-1:0] link_wr_data;

   assign process       = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || process;

   assign is_pop  = (in_ff.command == mssp_pkg::CMD_POP);
   assign sid_ok  = (32'(in_ff.stack_id) < NUM_STACKS);
   assign sid_idx = sid_ok ? SW'(in_ff.stack_id) : '0;
   assign cur_head = stack_head_ff[sid_idx];

   // forward the link read issued last cycle
   always_comb begin
      free_next_eff = (pend_valid_ff && !pend_is_pop_ff) ? link_rd_ff : free_next_ff;
      for (int s = 0; s < NUM_STACKS; s++) begin
         stack_next_eff[s] = (pend_valid_ff && pend_is_pop_ff && pend_sid_ff == SW'(s))
                             ? link_rd_ff : stack_next_ff[s];
      end
   end

   // link of the new next slot: unwritten slots still chain to the following one
   assign x_link   = is_pop ? stack_next_eff[sid_idx] : free_next_eff;
   assign x_read   = (x_link < fill_ff);
   assign x_direct = (x_link >= NIL) ? NIL : x_link + LW'(1);

   always_comb begin
      free_head_in   = free_head_ff;
      free_next_in   = free_next_eff;
      fill_in        = fill_ff;
      for (int s = 0; s < NUM_STACKS; s++) begin
         stack_head_in[s] = stack_head_ff[s];
         stack_next_in[s] = stack_next_eff[s];
      end
      pend_valid_in  = 1'b0;
      pend_is_pop_in = pend_is_pop_ff;
      pend_sid_in    = pend_sid_ff;
      link_wr_en     = 1'b0;
      link_wr_addr   = AW'(free_head_ff);
      link_wr_data   = cur_head;
      link_rd_en     = 1'b0;
      link_rd_addr   = AW'(x_link);
      word_wr_en     = 1'b0;
      word_rd_en     = 1'b0;
      word_addr      = AW'(free_head_ff);
      status_in      = mssp_pkg::ST_DONE;
      pop_hit_in     = 1'b0;

      if (process) begin
         if (!sid_ok) begin
            status_in = is_pop ? mssp_pkg::ST_UNDERFLOW : mssp_pkg::ST_OVERFLOW;
         end else if (!is_pop) begin
            if (free_head_ff >= NIL) begin
               status_in = mssp_pkg::ST_OVERFLOW;
            end else begin
               word_wr_en             = 1'b1;
               link_wr_en             = 1'b1;
               stack_head_in[sid_idx] = free_head_ff;
               stack_next_in[sid_idx] = cur_head;
               free_head_in           = free_next_eff;
               free_next_in           = x_direct;
               link_rd_en             = x_read;
               pend_valid_in          = x_read;
               pend_is_pop_in         = 1'b0;
               if (free_head_ff >= fill_ff) begin
                  fill_in = free_head_ff + LW'(1);
               end
            end
         end else begin
            if (cur_head >= NIL) begin
               status_in = mssp_pkg::ST_UNDERFLOW;
            end else begin
               word_rd_en             = 1'b1;
               word_addr              = AW'(cur_head);
               pop_hit_in             = 1'b1;
               link_wr_en             = 1'b1;
               link_wr_addr           = AW'(cur_head);
               link_wr_data           = free_head_ff;
               free_head_in           = cur_head;
               free_next_in           = free_head_ff;
               stack_head_in[sid_idx] = stack_next_eff[sid_idx];
               stack_next_in[sid_idx] = x_direct;
               link_rd_en             = x_read;
               pend_valid_in          = x_read;
               pend_is_pop_in         = 1'b1;
               pend_sid_in            = sid_idx;
            end
         end
      end

      pool_full_in   = (free_head_in >= NIL);
      stack_empty_in = !sid_ok || (stack_head_in[sid_idx] >= NIL);
   end

   // memories
   always_ff @(posedge clock) begin
      if (word_wr_en) begin
         word_mem[word_addr] <= in_ff.push_data;
      end
      if (word_rd_en) begin
         word_rd_ff <= word_mem[word_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_wr_en) begin
         link_mem[link_wr_addr] <= link_wr_data;
      end
      if (link_rd_en) begin
         link_rd_ff <= link_mem[link_rd_addr];
      end
   end

   // control and list state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         free_head_ff   <= '0;
         free_next_ff   <= LW'(1);
         fill_ff        <= '0;
         pend_valid_ff  <= 1'b0;
         pend_is_pop_ff <= 1'b0;
         pend_sid_ff    <= '0;
         for (int s = 0; s < NUM_STACKS; s++) begin
            stack_head_ff[s] <= NIL;
            stack_next_ff[s] <= NIL;
         end
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (process) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         free_head_ff   <= free_head_in;
         free_next_ff   <= free_next_in;
         fill_ff        <= fill_in;
         pend_valid_ff  <= pend_valid_in;
         pend_is_pop_ff <= pend_is_pop_in;
         pend_sid_ff    <= pend_sid_in;
         for (int s = 0; s < NUM_STACKS; s++) begin
            stack_head_ff[s] <= stack_head_in[s];
            stack_next_ff[s] <= stack_next_in[s];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_ff.command   <= req_chan.command;
         in_ff.stack_id  <= req_chan.stack_id;
         in_ff.push_data <= req_chan.push_data;
      end
      if (process) begin
         status_ff      <= status_in;
         pool_full_ff   <= pool_full_in;
         stack_empty_ff <= stack_empty_in;
         pop_hit_ff     <= pop_hit_in;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.pop_data    = pop_hit_ff ? word_rd_ff : '0;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.pool_full   = pool_full_ff;
   assign rsp_chan.stack_empty = stack_empty_ff;

   // assertions
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= NIL)
      else $error("fill count beyond pool size");

   a_free_not_on_stack: assert property (@(posedge clock) disable iff (reset)
      process && sid_ok && free_head_ff < NIL && cur_head < NIL |-> free_head_ff != cur_head)
      else $error("free head slot also heads a stack");

   a_pend_follows_op: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> $past(process))
      else $error("pending link read without an operation");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != mssp_pkg::ST_DONE |-> !pop_hit_ff)
      else $error("failed operation returns pop data");

   a_push_no_data: assert property (@(posedge clock) disable iff (reset)
      process && in_ff.command == mssp_pkg::CMD_PUSH |=> rsp_valid_ff && !pop_hit_ff)
      else $error("push response missing or carries pop data");

endmodule
